// File: rtl/gbfs_pkg.sv
package gbfs_pkg;

	localparam int COORD_W    = 12;
	localparam int SCORE_W    = 32;
	localparam int LEVEL_W    = 3;
	localparam int GRID_W     = 7;
	localparam int CELLNUM_W  = 9;
	localparam int REQ_W      = 3;
	localparam int CNT_W      = 8;
	localparam int QUOT_W     = 6;
	localparam int INDEX_W    = 13;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam int S_TDATA_W = 72;
	localparam int M_TDATA_W = 32;
	localparam int M_TUSER_W = 2;

	localparam logic [REQ_W-1:0] REQ_START      = 3'd0;
	localparam logic [REQ_W-1:0] REQ_LOCK       = 3'd1;
	localparam logic [REQ_W-1:0] REQ_UNLOCK_ALL = 3'd2;
	localparam logic [REQ_W-1:0] REQ_CANDIDATE  = 3'd3;
	localparam logic [REQ_W-1:0] REQ_READ       = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_FEAT    = 3'd5;

	localparam logic [GRID_W-1:0]  RST_GRID_COLS   = 7'd20;
	localparam logic [GRID_W-1:0]  RST_GRID_ROWS   = 7'd20;
	localparam logic [COORD_W-1:0] RST_CELL_WIDTH  = 12'd32;
	localparam logic [COORD_W-1:0] RST_CELL_HEIGHT = 12'd24;
	localparam logic [SCORE_W-1:0] RST_THRESHOLD   = 32'd1280;
	localparam logic [CNT_W-1:0]   RST_MAX_FEAT    = 8'd100;

	localparam logic [GRID_W-1:0] GRID_LIMIT = 7'd64;

	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [LEVEL_W-1:0] level;
	} cell_entry_t;

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_DIV,
		ST_LOOKUP,
		ST_UPDATE,
		ST_EMIT
	} state_t;

	function automatic logic [GRID_W-1:0] clamp_dim(input logic [GRID_W-1:0] v);
		logic [GRID_W-1:0] r;
		if (v == '0) begin
			r = GRID_W'(1);
		end else if (v > GRID_LIMIT) begin
			r = GRID_LIMIT;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// File: rtl/gbfs_div.sv
module gbfs_div import gbfs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [COORD_W-1:0] dividend,
	input  logic [COORD_W-1:0] divisor,
	output logic               busy,
	output logic [GRID_W-1:0]  quotient
);

	localparam int DSH_W = COORD_W + QUOT_W - 1;
	localparam int SAT_W = COORD_W + QUOT_W;
	localparam logic [1:0] STEPS = 2'(QUOT_W / 2);

	logic [COORD_W-1:0] rem_q;
	logic [DSH_W-1:0]   dsh_q;
	logic [QUOT_W-1:0]  quot_q;
	logic               sat_q;
	logic [1:0]         cnt_q;

	logic [DSH_W-1:0] rem_ext;
	logic [DSH_W-1:0] rem1;
	logic [DSH_W-1:0] rem2;
	logic [DSH_W-1:0] dsh_lo;
	logic             bit_hi;
	logic             bit_lo;
	logic             sat_now;

	// Two restoring steps per cycle. A quotient of 64 or more saturates.
	always_comb begin
		rem_ext = DSH_W'(rem_q);
		bit_hi  = rem_ext >= dsh_q;
		rem1    = bit_hi ? rem_ext - dsh_q : rem_ext;
		dsh_lo  = dsh_q >> 1;
		bit_lo  = rem1 >= dsh_lo;
		rem2    = bit_lo ? rem1 - dsh_lo : rem1;
		sat_now = SAT_W'(dividend) >= {divisor, {QUOT_W{1'b0}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= STEPS;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= dividend;
			dsh_q  <= {divisor, {(QUOT_W-1){1'b0}}};
			quot_q <= '0;
			sat_q  <= sat_now;
		end else if (cnt_q != '0) begin
			rem_q  <= rem2[COORD_W-1:0];
			dsh_q  <= dsh_q >> 2;
			quot_q <= {quot_q[QUOT_W-3:0], bit_hi, bit_lo};
		end
	end

	assign busy     = cnt_q != '0;
	assign quotient = sat_q ? GRID_LIMIT : GRID_W'(quot_q);

endmodule

// File: rtl/grid_bucket_feature_select_unit.sv
// Grid-bucketed corner selection. The unit handles one request at a time and
// keeps each cell's best corner in one memory and its lock bit in another,
// both with one read and one write port and a registered read. A lock or
// candidate passes through the transaction, the two column and row dividers
// (two quotient bits per cycle), the registered row times columns index, one
// memory read and one write back. A read request reads both memories on
// acceptance and loads the output register once it is free. A start clears
// every score entry and an unlock-all every lock bit, one entry a cycle.
// After reset both memories are cleared before s_axis_tready rises;
// configuration writes are accepted at any time.
module grid_bucket_feature_select_unit import gbfs_pkg::*; #(
	parameter int MAX_CELLS = 512
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,

	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// point_x, point_y, corner_level, corner_score, cell_number, zero fill
	input  logic [S_TDATA_W-1:0]  s_axis_tdata,
	// req_type
	input  logic [REQ_W-1:0]      s_axis_tuser,

	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// feature_x, feature_y, feature_level, zero fill
	output logic [M_TDATA_W-1:0]  m_axis_tdata,
	// taken, count_reached
	output logic [M_TUSER_W-1:0]  m_axis_tuser
);

	localparam int ADDR_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
	localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(MAX_CELLS - 1);
	localparam logic [INDEX_W-1:0] MAX_CELLS_W = INDEX_W'(MAX_CELLS);

	logic [GRID_W-1:0]  grid_cols_q;
	logic [GRID_W-1:0]  grid_rows_q;
	logic [COORD_W-1:0] cell_width_q;
	logic [COORD_W-1:0] cell_height_q;
	logic [SCORE_W-1:0] threshold_q;
	logic [CNT_W-1:0]   max_feat_q;

	state_t state_q;
	state_t state_d;

	logic [ADDR_W-1:0]  sweep_q;
	logic               sweep_score_q;
	logic               sweep_lock_q;
	logic [CNT_W-1:0]   count_q;

	logic [REQ_W-1:0]   req_q;
	logic [COORD_W-1:0] x_q;
	logic [COORD_W-1:0] y_q;
	logic [LEVEL_W-1:0] level_q;
	logic [SCORE_W-1:0] score_q;
	logic               cn_ok_q;
	logic [INDEX_W-1:0] k_q;
	logic               k_ok_q;

	cell_entry_t        entry_mem [MAX_CELLS];
	logic               lock_mem  [MAX_CELLS];
	cell_entry_t        entry_rd_q;
	logic               lock_rd_q;

	logic               out_valid_q;
	logic [M_TDATA_W-1:0] out_data_q;
	logic [M_TUSER_W-1:0] out_user_q;

	logic               in_accept;
	logic [REQ_W-1:0]   in_req;
	logic [COORD_W-1:0] in_x;
	logic [COORD_W-1:0] in_y;
	logic [LEVEL_W-1:0] in_level;
	logic [SCORE_W-1:0] in_score;
	logic [CELLNUM_W-1:0] in_cn;

	logic [GRID_W-1:0]  cols_eff;
	logic [GRID_W-1:0]  rows_eff;
	logic [COORD_W-1:0] cw_eff;
	logic [COORD_W-1:0] ch_eff;
	logic [INDEX_W-1:0] active;

	logic               div_start;
	logic               div_col_busy;
	logic               div_row_busy;
	logic [GRID_W-1:0]  q_col;
	logic [GRID_W-1:0]  q_row;
	logic [GRID_W-1:0]  col;
	logic [GRID_W-1:0]  row;
	logic [INDEX_W-1:0] k_next;

	logic               rd_en;
	logic [ADDR_W-1:0]  rd_addr;
	logic               entry_we;
	logic [ADDR_W-1:0]  entry_waddr;
	cell_entry_t        entry_wdata;
	logic               lock_we;
	logic [ADDR_W-1:0]  lock_waddr;
	logic               lock_wdata;

	logic               out_free;
	logic               out_load;
	logic               take;
	logic [CNT_W-1:0]   count_next;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = state_q == ST_IDLE;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	assign in_req   = s_axis_tuser;
	assign in_x     = s_axis_tdata[11:0];
	assign in_y     = s_axis_tdata[23:12];
	assign in_level = s_axis_tdata[26:24];
	assign in_score = s_axis_tdata[58:27];
	assign in_cn    = s_axis_tdata[67:59];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_cols_q   <= RST_GRID_COLS;
			grid_rows_q   <= RST_GRID_ROWS;
			cell_width_q  <= RST_CELL_WIDTH;
			cell_height_q <= RST_CELL_HEIGHT;
			threshold_q   <= RST_THRESHOLD;
			max_feat_q    <= RST_MAX_FEAT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_GRID_COLS:   grid_cols_q   <= cfg_data[GRID_W-1:0];
				CFG_GRID_ROWS:   grid_rows_q   <= cfg_data[GRID_W-1:0];
				CFG_CELL_WIDTH:  cell_width_q  <= cfg_data[COORD_W-1:0];
				CFG_CELL_HEIGHT: cell_height_q <= cfg_data[COORD_W-1:0];
				CFG_THRESHOLD:   threshold_q   <= cfg_data[SCORE_W-1:0];
				CFG_MAX_FEAT:    max_feat_q    <= cfg_data[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cols_eff = clamp_dim(grid_cols_q);
		rows_eff = clamp_dim(grid_rows_q);
		cw_eff   = (cell_width_q == '0) ? COORD_W'(1) : cell_width_q;
		ch_eff   = (cell_height_q == '0) ? COORD_W'(1) : cell_height_q;
		active   = INDEX_W'(cols_eff * rows_eff);
		if (active > MAX_CELLS_W) begin
			active = MAX_CELLS_W;
		end
	end

	assign div_start = in_accept && (in_req == REQ_LOCK || in_req == REQ_CANDIDATE);

	gbfs_div u_div_col (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (in_x),
		.divisor  (cw_eff),
		.busy     (div_col_busy),
		.quotient (q_col)
	);

	gbfs_div u_div_row (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (in_y),
		.divisor  (ch_eff),
		.busy     (div_row_busy),
		.quotient (q_row)
	);

	always_comb begin
		col    = (q_col >= cols_eff) ? cols_eff - GRID_W'(1) : q_col;
		row    = (q_row >= rows_eff) ? rows_eff - GRID_W'(1) : q_row;
		k_next = INDEX_W'(row * cols_eff) + INDEX_W'(col);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	assign out_free = !out_valid_q || m_axis_tready;

	always_comb begin
		state_d  = state_q;
		rd_en    = 1'b0;
		rd_addr  = k_q[ADDR_W-1:0];
		out_load = 1'b0;
		case (state_q)
			ST_SWEEP: begin
				if (sweep_q == LAST_ADDR) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				rd_addr = INDEX_W'(in_cn) >> 0 == '0 ? '0 : ADDR_W'(INDEX_W'(in_cn));
				if (in_accept) begin
					case (in_req)
						REQ_START, REQ_UNLOCK_ALL: state_d = ST_SWEEP;
						REQ_LOCK, REQ_CANDIDATE:   state_d = ST_DIV;
						REQ_READ: begin
							rd_en   = 1'b1;
							state_d = ST_EMIT;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_DIV: begin
				if (!div_col_busy && !div_row_busy) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				rd_en   = 1'b1;
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				state_d = ST_IDLE;
			end
			ST_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q       <= '0;
			sweep_score_q <= 1'b1;
			sweep_lock_q  <= 1'b1;
		end else if (state_q == ST_SWEEP) begin
			sweep_q <= (sweep_q == LAST_ADDR) ? '0 : sweep_q + ADDR_W'(1);
		end else if (in_accept) begin
			sweep_score_q <= in_req == REQ_START;
			sweep_lock_q  <= in_req == REQ_UNLOCK_ALL;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			req_q   <= in_req;
			x_q     <= in_x;
			y_q     <= in_y;
			level_q <= in_level;
			score_q <= in_score;
			cn_ok_q <= INDEX_W'(in_cn) < active;
		end
		if (state_q == ST_DIV) begin
			k_q    <= k_next;
			k_ok_q <= k_next < active;
		end
	end

	always_comb begin
		entry_we          = 1'b0;
		entry_waddr       = k_q[ADDR_W-1:0];
		entry_wdata.score = score_q;
		entry_wdata.x     = x_q;
		entry_wdata.y     = y_q;
		entry_wdata.level = level_q;
		lock_we           = 1'b0;
		lock_waddr        = k_q[ADDR_W-1:0];
		lock_wdata        = 1'b1;
		if (state_q == ST_SWEEP) begin
			entry_we    = sweep_score_q;
			entry_waddr = sweep_q;
			entry_wdata = '0;
			lock_we     = sweep_lock_q;
			lock_waddr  = sweep_q;
			lock_wdata  = 1'b0;
		end else if (state_q == ST_UPDATE && k_ok_q) begin
			lock_we  = req_q == REQ_LOCK;
			entry_we = req_q == REQ_CANDIDATE && !lock_rd_q && score_q > entry_rd_q.score;
		end
	end

	always_ff @(posedge clk) begin
		if (entry_we) begin
			entry_mem[entry_waddr] <= entry_wdata;
		end
		if (rd_en) begin
			entry_rd_q <= entry_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (lock_we) begin
			lock_mem[lock_waddr] <= lock_wdata;
		end
		if (rd_en) begin
			lock_rd_q <= lock_mem[rd_addr];
		end
	end

	always_comb begin
		take       = cn_ok_q && entry_rd_q.score > threshold_q && count_q < max_feat_q;
		count_next = count_q + CNT_W'(take);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (in_accept && in_req == REQ_START) begin
			count_q <= '0;
		end else if (out_load) begin
			count_q <= count_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (take) begin
				out_data_q <= M_TDATA_W'({entry_rd_q.level, entry_rd_q.y, entry_rd_q.x});
			end else begin
				out_data_q <= '0;
			end
			out_user_q <= {count_next >= max_feat_q, take};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps

module tb;
	import gbfs_pkg::*;

	localparam int TB_CELLS = 512;
	localparam int GRID_MAX = 64;
	localparam int SETTLE_CYCLES = TB_CELLS + 64;
	localparam int LONG_HOLD = 400;
	localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd5;
	localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;

	typedef struct packed {
		logic [REQ_W-1:0]     req;
		logic [COORD_W-1:0]   x;
		logic [COORD_W-1:0]   y;
		logic [LEVEL_W-1:0]   lvl;
		logic [SCORE_W-1:0]   score;
		logic [CELLNUM_W-1:0] cnum;
	} bucket_req_t;

	typedef struct packed {
		logic [COORD_W-1:0] fx;
		logic [COORD_W-1:0] fy;
		logic [LEVEL_W-1:0] flvl;
		logic               taken;
		logic               full;
	} feature_t;

	typedef struct {
		bucket_req_t r;
		bit          typed;
		feature_t    f;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [S_TDATA_W-1:0]  s_axis_tdata;
	logic [REQ_W-1:0]      s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [M_TDATA_W-1:0]  m_axis_tdata;
	logic [M_TUSER_W-1:0]  m_axis_tuser;

	logic [GRID_W-1:0]  cfg_cols;
	logic [GRID_W-1:0]  cfg_rows;
	logic [COORD_W-1:0] cfg_cw;
	logic [COORD_W-1:0] cfg_ch;
	logic [SCORE_W-1:0] cfg_thr;
	logic [CNT_W-1:0]   cfg_maxf;

	logic [SCORE_W-1:0] cell_score [TB_CELLS];
	logic [COORD_W-1:0] cell_x [TB_CELLS];
	logic [COORD_W-1:0] cell_y [TB_CELLS];
	logic [LEVEL_W-1:0] cell_lvl [TB_CELLS];
	bit                 cell_lock [TB_CELLS];
	int unsigned        taken_cnt;

	feature_t    feature_q [$];
	dir_row_t    dir_tab [$];
	int unsigned mismatch_cnt;
	int unsigned tx_calm;
	bit          long_hold_req;

	logic [31:0] phase_cfg [0:7][0:5] = '{
		'{32'd4, 32'd3, 32'd100, 32'd100, 32'd1000, 32'd255},
		'{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0},
		'{32'd127, 32'd127, 32'd4095, 32'd4095, 32'hFFFF_FFFF, 32'd1},
		'{32'd64, 32'd8, 32'd64, 32'd512, 32'd8000, 32'd10},
		'{32'd30, 32'd20, 32'd50, 32'd60, 32'd500, 32'd40},
		'{32'd1, 32'd64, 32'd4095, 32'd1, 32'd1, 32'd200},
		'{32'd64, 32'd64, 32'd1, 32'd1, 32'd2000, 32'd255},
		'{32'd20, 32'd20, 32'd32, 32'd24, 32'd1280, 32'd100}
	};

	grid_bucket_feature_select_unit #(
		.MAX_CELLS(TB_CELLS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int unsigned eff_dim(input logic [GRID_W-1:0] v);
		if (v == '0) begin
			return 1;
		end
		return (v > GRID_MAX) ? GRID_MAX : v;
	endfunction

	function automatic int unsigned active_cells();
		int unsigned n;
		n = eff_dim(cfg_cols) * eff_dim(cfg_rows);
		return (n > TB_CELLS) ? TB_CELLS : n;
	endfunction

	function automatic int unsigned point_cell(input logic [COORD_W-1:0] x, y);
		int unsigned cols, rows, cw, ch, col, row, k;
		cols = eff_dim(cfg_cols);
		rows = eff_dim(cfg_rows);
		cw = (cfg_cw == '0) ? 1 : cfg_cw;
		ch = (cfg_ch == '0) ? 1 : cfg_ch;
		col = x / cw;
		row = y / ch;
		if (col >= cols) begin
			col = cols - 1;
		end
		if (row >= rows) begin
			row = rows - 1;
		end
		k = row * cols + col;
		return (k < active_cells()) ? k : TB_CELLS;
	endfunction

	function automatic bit bucket_apply(input bucket_req_t r, output feature_t f);
		int unsigned k;
		bit has;
		f = '0;
		has = 1'b0;
		case (r.req)
			REQ_START: begin
				for (k = 0; k < TB_CELLS; k++) begin
					cell_score[k] = '0;
				end
				taken_cnt = 0;
			end
			REQ_LOCK: begin
				k = point_cell(r.x, r.y);
				if (k < TB_CELLS) begin
					cell_lock[k] = 1'b1;
				end
			end
			REQ_UNLOCK_ALL: begin
				for (k = 0; k < TB_CELLS; k++) begin
					cell_lock[k] = 1'b0;
				end
			end
			REQ_CANDIDATE: begin
				k = point_cell(r.x, r.y);
				if (k < TB_CELLS && !cell_lock[k] && r.score > cell_score[k]) begin
					cell_score[k] = r.score;
					cell_x[k] = r.x;
					cell_y[k] = r.y;
					cell_lvl[k] = r.lvl;
				end
			end
			REQ_READ: begin
				k = r.cnum;
				has = 1'b1;
				if (k < active_cells() && cell_score[k] > cfg_thr && taken_cnt < cfg_maxf) begin
					taken_cnt++;
					f.fx = cell_x[k];
					f.fy = cell_y[k];
					f.flvl = cell_lvl[k];
					f.taken = 1'b1;
				end
				f.full = (taken_cnt >= cfg_maxf);
			end
			default: begin
			end
		endcase
		return has;
	endfunction

	function automatic int unsigned gap_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
	endfunction

	function automatic logic [COORD_W-1:0] rand_coord(input int unsigned span);
		if ($urandom_range(0, 7) == 0 || span > 4095) begin
			return COORD_W'($urandom_range(0, 4095));
		end
		return COORD_W'($urandom_range(0, span));
	endfunction

	function automatic bucket_req_t rand_fields(input logic [REQ_W-1:0] req);
		bucket_req_t r;
		logic [32:0] s;
		int unsigned cw, ch;
		cw = (cfg_cw == '0) ? 1 : cfg_cw;
		ch = (cfg_ch == '0) ? 1 : cfg_ch;
		r.req = req;
		r.x = rand_coord(eff_dim(cfg_cols) * cw + cw / 2);
		r.y = rand_coord(eff_dim(cfg_rows) * ch + ch / 2);
		r.lvl = LEVEL_W'($urandom_range(0, 7));
		case ($urandom_range(0, 3))
			0: s = {1'b0, $urandom};
			1: s = (cfg_thr < 8) ? $urandom_range(0, 16)
				: {1'b0, cfg_thr} - 33'd8 + $urandom_range(0, 16);
			2: s = $urandom_range(0, 4095);
			default: s = {1'b0, cfg_thr} + $urandom_range(1, 1 << 20);
		endcase
		if (s[32]) begin
			s = 33'h0_FFFF_FFFF;
		end
		r.score = s[31:0];
		if ($urandom_range(0, 6) == 0) begin
			r.cnum = CELLNUM_W'($urandom_range(0, 511));
		end else begin
			r.cnum = CELLNUM_W'($urandom_range(0, active_cells() - 1));
		end
		return r;
	endfunction

	function automatic void tab_add(input logic [REQ_W-1:0] req, input int unsigned x, y, lvl,
			input logic [SCORE_W-1:0] score, input int unsigned cnum, input int unsigned typed,
			input int unsigned fx, fy, flvl, input int unsigned tk, full);
		dir_row_t row;
		row.r = '{req: req, x: COORD_W'(x), y: COORD_W'(y), lvl: LEVEL_W'(lvl), score: score,
			cnum: CELLNUM_W'(cnum)};
		row.typed = (typed != 0);
		row.f = '{fx: COORD_W'(fx), fy: COORD_W'(fy), flvl: LEVEL_W'(flvl), taken: (tk != 0),
			full: (full != 0)};
		dir_tab.insert(dir_tab.size(), row);
	endfunction

	task automatic send_req(input bucket_req_t r, input bit typed, input feature_t tf);
		feature_t f;
		int unsigned gap;
		s_axis_tdata <= S_TDATA_W'({r.cnum, r.score, r.lvl, r.y, r.x});
		s_axis_tuser <= r.req;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		if (bucket_apply(r, f)) begin
			feature_q.insert(feature_q.size(), typed ? tf : f);
		end
		@(negedge clk);
		if (tx_calm > 0) begin
			tx_calm--;
		end else if ($urandom_range(0, 19) == 0) begin
			tx_calm = $urandom_range(20, 60);
		end else if ($urandom_range(0, 2) == 0) begin
			gap = gap_len();
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic drain_block();
		s_axis_tvalid <= 1'b0;
		while (feature_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_GRID_COLS:   cfg_cols = val[GRID_W-1:0];
			CFG_GRID_ROWS:   cfg_rows = val[GRID_W-1:0];
			CFG_CELL_WIDTH:  cfg_cw = val[COORD_W-1:0];
			CFG_CELL_HEIGHT: cfg_ch = val[COORD_W-1:0];
			CFG_THRESHOLD:   cfg_thr = val[SCORE_W-1:0];
			CFG_MAX_FEAT:    cfg_maxf = val[CNT_W-1:0];
			default: begin
			end
		endcase
		@(negedge clk);
	endtask

	task automatic load_cfg(input logic [31:0] c [0:5]);
		cfg_write(CFG_GRID_COLS, c[0]);
		cfg_write(CFG_GRID_ROWS, c[1]);
		cfg_write(CFG_CELL_WIDTH, c[2]);
		cfg_write(CFG_CELL_HEIGHT, c[3]);
		cfg_write(CFG_THRESHOLD, c[4]);
		cfg_write(CFG_MAX_FEAT, c[5]);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input int unsigned n_items, input bit squeeze);
		int unsigned done, i, nc, nr;
		bucket_req_t r;
		feature_t none;
		none = '0;
		done = 0;
		while (done < n_items) begin
			r = rand_fields(($urandom_range(0, 4) == 0) ? REQ_UNLOCK_ALL : REQ_START);
			send_req(r, 1'b0, none);
			done++;
			nc = $urandom_range(5, 40);
			for (i = 0; i < nc && done < n_items; i++) begin
				if ($urandom_range(0, 14) == 0) begin
					send_req(rand_fields(REQ_W'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI))),
						1'b0, none);
				end
				send_req(rand_fields(($urandom_range(0, 9) == 0) ? REQ_LOCK : REQ_CANDIDATE),
					1'b0, none);
				done++;
			end
			if (squeeze) begin
				long_hold_req = 1'b1;
				squeeze = 1'b0;
			end
			nr = $urandom_range(4, 30);
			for (i = 0; i < nr && done < n_items; i++) begin
				send_req(rand_fields(REQ_READ), 1'b0, none);
				done++;
			end
		end
	endtask

	initial begin : rx_side
		int unsigned left;
		logic lvl;
		left = 0;
		lvl = 1'b0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				lvl = 1'b0;
				left = LONG_HOLD;
			end else if (left == 0) begin
				if ($urandom_range(0, 3) == 0) begin
					lvl = 1'b0;
					left = gap_len();
				end else begin
					lvl = 1'b1;
					left = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 300)
						: $urandom_range(1, 20);
				end
			end
			left--;
			m_axis_tready <= lvl;
		end
	end

	function automatic void field_check(input string name, input int unsigned want, got);
		if (want != got) begin
			mismatch_cnt++;
			$display("%0t %s expected %0h actual %0h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin : result_mon
		feature_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.fx = m_axis_tdata[11:0];
			got.fy = m_axis_tdata[23:12];
			got.flvl = m_axis_tdata[26:24];
			got.taken = m_axis_tuser[0];
			got.full = m_axis_tuser[1];
			if (feature_q.size() == 0) begin
				mismatch_cnt++;
				$display("%0t unexpected transaction expected none actual %h", $time, got);
			end else begin
				want = feature_q.pop_front();
				field_check("feature_x", want.fx, got.fx);
				field_check("feature_y", want.fy, got.fy);
				field_check("feature_level", want.flvl, got.flvl);
				field_check("taken", want.taken, got.taken);
				field_check("count_reached", want.full, got.full);
			end
		end
	end

	initial begin
		#4000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : stim
		int unsigned k, p;
		logic [31:0] rc [0:5];
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		mismatch_cnt = 0;
		tx_calm = 0;
		long_hold_req = 1'b0;
		cfg_cols = RST_GRID_COLS;
		cfg_rows = RST_GRID_ROWS;
		cfg_cw = RST_CELL_WIDTH;
		cfg_ch = RST_CELL_HEIGHT;
		cfg_thr = RST_THRESHOLD;
		cfg_maxf = RST_MAX_FEAT;
		for (k = 0; k < TB_CELLS; k++) begin
			cell_score[k] = '0;
			cell_x[k] = '0;
			cell_y[k] = '0;
			cell_lvl[k] = '0;
			cell_lock[k] = 1'b0;
		end
		taken_cnt = 0;

		tab_add(REQ_READ, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
		tab_add(REQ_READ, 4095, 4095, 7, 32'hFFFF_FFFF, 511, 1, 0, 0, 0, 0, 0);
		tab_add(REQ_CANDIDATE, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0);
		tab_add(REQ_READ, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0);
		tab_add(REQ_CANDIDATE, 4095, 4095, 7, 1281, 0, 0, 0, 0, 0, 0, 0);
		tab_add(REQ_READ, 0, 0, 0, 0, 399, 1, 4095, 4095, 7, 1, 0);
		tab_add(REQ_CANDIDATE, 33, 25, 3, 1280, 0, 0, 0, 0, 0, 0, 0);
		tab_add(REQ_READ, 0, 0, 0, 0, 21, 1, 0, 0, 0, 0, 0);
		tab_add(REQ_CANDIDATE, 100, 100, 6, 0, 0, 0, 0, 0, 0, 0, 0);
		tab_add(REQ_CANDIDATE, 40, 30, 5, 5000, 0, 0, 0, 0, 0, 0, 0);
		tab_add(REQ_CANDIDATE, 50, 40, 2, 4999, 0, 0, 0, 0, 0, 0, 0);
		tab_add(REQ_LOCK, 63, 47, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		tab_add(REQ_CANDIDATE, 34, 26, 1, 9000, 0, 0, 0, 0, 0, 0, 0);
		tab_add(REQ_READ, 0, 0, 0, 0, 21, 0, 0, 0, 0, 0, 0);
		tab_add(REQ_UNLOCK_ALL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		tab_add(REQ_CANDIDATE, 34, 26, 1, 9000, 0, 0, 0, 0, 0, 0, 0);
		tab_add(REQ_READ, 0, 0, 0, 0, 21, 0, 0, 0, 0, 0, 0);
		tab_add(REQ_UNUSED_LO, 4095, 4095, 7, 32'hFFFF_FFFF, 511, 0, 0, 0, 0, 0, 0);
		tab_add(REQ_UNUSED_HI, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		tab_add(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		tab_add(REQ_START, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		tab_add(REQ_READ, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
		tab_add(REQ_LOCK, 4095, 4095, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		tab_add(REQ_START, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		tab_add(REQ_CANDIDATE, 4000, 4000, 4, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0);
		tab_add(REQ_READ, 0, 0, 0, 0, 399, 1, 0, 0, 0, 0, 0);
		tab_add(REQ_UNLOCK_ALL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_tab[i]) begin
			send_req(dir_tab[i].r, dir_tab[i].typed, dir_tab[i].f);
		end

		for (p = 0; p < 10; p++) begin
			drain_block();
			if (p < 8) begin
				load_cfg(phase_cfg[p]);
			end else begin
				rc[0] = $urandom_range(0, 127);
				rc[1] = $urandom_range(0, 127);
				rc[2] = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 200)
					: $urandom_range(0, 4095);
				rc[3] = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 200)
					: $urandom_range(0, 4095);
				rc[4] = $urandom_range(0, 1 << 16);
				rc[5] = $urandom_range(0, 255);
				load_cfg(rc);
			end
			run_phase(162, (p == 0 || p == 4));
		end

		drain_block();
		if (mismatch_cnt == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
